>>> rtl/rlqwt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the run-length queue with weighted take.
// Depends on nothing; every other file in rtl imports it.
package rlqwt_pkg;

	localparam int unsigned ValueW  = 16;
	localparam int unsigned CountW  = 32;
	localparam int unsigned SumW    = 48;
	localparam int unsigned StatusW = 2;

	localparam logic [StatusW-1:0] StOk    = 2'd0;
	localparam logic [StatusW-1:0] StFull  = 2'd1;
	localparam logic [StatusW-1:0] StShort = 2'd2;

	localparam logic ModePush = 1'b0;
	localparam logic ModeTake = 1'b1;

	// One stored run: a unit value and its repeat count.
	typedef struct packed {
		logic [ValueW-1:0] value;
		logic [CountW-1:0] count;
	} run_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

endpackage

>>> rtl/rlqwt_ram.sv
`timescale 1ns / 1ps
// Run store: one write port and one read port with a registered read.
// Depends on rlqwt_pkg for the run_t record.
module rlqwt_ram #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  rlqwt_pkg::run_t               wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output rlqwt_pkg::run_t               rd_data
);
	import rlqwt_pkg::*;

	run_t mem [DEPTH];
	run_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/run_length_queue_weighted_take_core.sv
`timescale 1ns / 1ps
// Run-length queue: a push item appends a run (value, repeat count) at the tail and
// passes through the done state, where its result is loaded into the output
// register. A take item removes the requested units from the head and returns the
// sum of value times units removed; it walks the runs it touches one after another
// through the single read port of the run store (read, compare, multiply, accumulate
// per run) and then passes through the done state. The next item is accepted in the
// cycle after a result is loaded; the done state waits while the output
// register is held. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken. Status is 0 for ok, 1 for a push
// dropped on a full queue and 2 for a take that asked for more units than were
// stored. The store needs no clearing.
// Depends on rlqwt_pkg and rlqwt_ram.
module run_length_queue_weighted_take_core #(
	parameter int unsigned QUEUE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [rlqwt_pkg::ValueW-1:0]       run_value,
	input  logic [rlqwt_pkg::CountW-1:0]       unit_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rlqwt_pkg::SumW-1:0]         weighted_sum,
	output logic [rlqwt_pkg::StatusW-1:0]      status
);
	import rlqwt_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
	localparam logic [OW-1:0] FullOcc = OW'(QUEUE_DEPTH);

	state_t state_q, state_d;

	logic [AW-1:0]      head_q, tail_q;
	logic [OW-1:0]      occ_q;
	logic [CountW-1:0]  want_q;
	logic [SumW-1:0]    sum_q;
	logic [StatusW-1:0] res_status_q;
	logic               out_valid_q;
	logic [SumW-1:0]    out_sum_q;
	logic [StatusW-1:0] out_status_q;

	logic [CountW-1:0]  take_s1;
	logic [CountW-1:0]  rem_s1;
	logic [ValueW-1:0]  val_s1;
	logic               whole_s1;
	logic [SumW-1:0]    prod_s2;

	logic    in_accept;
	logic    out_free;
	logic    push_ok;
	logic    mem_we;
	logic [AW-1:0] mem_waddr;
	run_t    mem_wdata;
	logic    mem_re;
	run_t    rd_run;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
		ring_next = (pos == LastIdx) ? '0 : pos + AW'(1);
	endfunction

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign push_ok   = (unit_count != '0) && (occ_q != FullOcc);

	rlqwt_ram #(
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(head_q),
		.rd_data(rd_run)
	);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = '{value: run_value, count: unit_count};
		mem_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (mode == ModePush) begin
						mem_we  = push_ok;
						state_d = ST_DONE;
					end else if (unit_count == '0 || occ_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				mem_re  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				// A split run keeps its value and holds the remainder at the head.
				mem_we    = !whole_s1;
				mem_waddr = head_q;
				mem_wdata = '{value: val_s1, count: rem_s1};
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				state_d = (want_q != '0 && occ_q != '0) ? ST_RD : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			if (state_q == ST_IDLE && in_accept && mode == ModePush && push_ok) begin
				tail_q <= ring_next(tail_q);
				occ_q  <= occ_q + OW'(1);
			end else if (state_q == ST_MUL && whole_s1) begin
				head_q <= ring_next(head_q);
				occ_q  <= occ_q - OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				want_q <= unit_count;
				sum_q  <= '0;
				if (mode == ModePush) begin
					res_status_q <= (unit_count != '0 && occ_q == FullOcc) ? StFull : StOk;
				end else begin
					res_status_q <= (unit_count != '0 && occ_q == '0) ? StShort : StOk;
				end
			end
			ST_CMP: begin
				if (want_q < rd_run.count) begin
					take_s1  <= want_q;
					whole_s1 <= 1'b0;
				end else begin
					take_s1  <= rd_run.count;
					whole_s1 <= 1'b1;
				end
				rem_s1 <= rd_run.count - want_q;
				val_s1 <= rd_run.value;
			end
			ST_MUL: begin
				prod_s2 <= {{(SumW-CountW){1'b0}}, take_s1} * {{(SumW-ValueW){1'b0}}, val_s1};
				want_q  <= want_q - take_s1;
			end
			ST_ACC: begin
				sum_q <= sum_q + prod_s2;
				res_status_q <= (want_q != '0 && occ_q == '0) ? StShort : StOk;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_sum_q    <= sum_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign weighted_sum = out_sum_q;
	assign status       = out_status_q;

	// The number of stored runs never passes the ring size.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FullOcc)
		else $error("occupancy exceeds queue depth");

	// An empty or full ring has its head and tail at the same place.
	a_ring_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == FullOcc) |-> head_q == tail_q)
		else $error("ring pointers disagree with occupancy");

	// A run is only walked while the queue holds at least one run.
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_MUL) |-> occ_q != '0)
		else $error("head run walked on an empty queue");

	// Every stored run has a nonzero count, so the head read never returns zero.
	a_head_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> rd_run.count != '0)
		else $error("head run read with zero count");

	// A split leaves the run in place and takes every requested unit.
	a_split_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && !whole_s1) |=> want_q == '0)
		else $error("split run left units outstanding");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for run_length_queue_weighted_take_core: a directed table, a fill of the queue
// past full, then random pushes and takes, each result checked against its typed row or a
// run queue kept here. Depends on rlqwt_pkg and the core RTL.
module tb;
	import rlqwt_pkg::*;

	localparam int unsigned QDEPTH = 1024;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 20000;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_REPORTS = 40;
	localparam int NROWS = 21;

	typedef struct packed {
		logic [SumW-1:0]    sum;
		logic [StatusW-1:0] status;
	} outcome_t;

	typedef struct packed {
		logic               mode;
		logic [ValueW-1:0]  value;
		logic [CountW-1:0]  count;
		logic               typed;
		logic [SumW-1:0]    sum;
		logic [StatusW-1:0] status;
	} step_row_t;

	// Rows with typed set carry their result; the rest are left to the run queue below.
	localparam step_row_t STEPS [NROWS] = '{
		'{ModeTake, 16'hFFFF, 32'h0000_0000, 1'b1, 48'd0, StOk},
		'{ModeTake, 16'h0000, 32'h0000_0005, 1'b1, 48'd0, StShort},
		'{ModePush, 16'hFFFF, 32'h0000_0000, 1'b1, 48'd0, StOk},
		'{ModePush, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 48'd0, StOk},
		'{ModeTake, 16'h0000, 32'hFFFF_FFFF, 1'b1, 48'hFFFE_FFFF_0001, StOk},
		'{ModeTake, 16'h0000, 32'h0000_0001, 1'b1, 48'd0, StShort},
		'{ModePush, 16'h0000, 32'h0000_0001, 1'b1, 48'd0, StOk},
		'{ModePush, 16'h0003, 32'h0000_0004, 1'b1, 48'd0, StOk},
		'{ModePush, 16'h8000, 32'h0000_0002, 1'b1, 48'd0, StOk},
		'{ModeTake, 16'h1234, 32'h0000_0002, 1'b0, 48'd0, StOk},
		'{ModeTake, 16'hFFFF, 32'h0000_0000, 1'b1, 48'd0, StOk},
		'{ModeTake, 16'h0000, 32'h0000_0004, 1'b0, 48'd0, StOk},
		'{ModeTake, 16'h5A5A, 32'h0000_0003, 1'b0, 48'd0, StOk},
		'{ModePush, 16'hAAAA, 32'h5555_5555, 1'b1, 48'd0, StOk},
		'{ModePush, 16'h5555, 32'hAAAA_AAAA, 1'b1, 48'd0, StOk},
		'{ModePush, 16'h0001, 32'h8000_0000, 1'b1, 48'd0, StOk},
		'{ModeTake, 16'h0000, 32'h8000_0000, 1'b0, 48'd0, StOk},
		'{ModeTake, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 48'd0, StOk},
		'{ModePush, 16'h7FFF, 32'h0000_FFFF, 1'b1, 48'd0, StOk},
		'{ModeTake, 16'h0000, 32'h0000_0001, 1'b0, 48'd0, StOk},
		'{ModeTake, 16'h0000, 32'h0000_FFFF, 1'b0, 48'd0, StOk}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               mode = ModePush;
	logic [ValueW-1:0]  run_value = '0;
	logic [CountW-1:0]  unit_count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SumW-1:0]    weighted_sum;
	logic [StatusW-1:0] status;

	// Behavioural copy of the run queue.
	logic [ValueW-1:0] held_value [QDEPTH];
	logic [CountW-1:0] held_count [QDEPTH];
	int unsigned       q_head = 0;
	int unsigned       q_tail = 0;
	int unsigned       q_runs = 0;

	outcome_t pending [$];
	int       errors = 0;
	int       idle_cycles = 0;
	bit       calm = 1'b0;
	bit       hold_request = 1'b0;

	run_length_queue_weighted_take_core #(
		.QUEUE_DEPTH(QDEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.run_value(run_value),
		.unit_count(unit_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.weighted_sum(weighted_sum),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one item to the run queue and returns the sum and status it yields.
	function automatic outcome_t apply_step(input logic m, input logic [ValueW-1:0] v,
			input logic [CountW-1:0] c);
		outcome_t          r;
		logic [CountW-1:0] want;
		logic [CountW-1:0] have;
		logic [CountW-1:0] grab;
		r.sum = '0;
		r.status = StOk;
		if (m == ModePush) begin
			if (c != 0) begin
				if (q_runs >= QDEPTH) begin
					r.status = StFull;
				end else begin
					held_value[q_tail] = v;
					held_count[q_tail] = c;
					q_tail = (q_tail + 1 == QDEPTH) ? 0 : q_tail + 1;
					q_runs++;
				end
			end
		end else begin
			want = c;
			while (want != 0 && q_runs != 0) begin
				have = held_count[q_head];
				grab = (want < have) ? want : have;
				r.sum = r.sum + SumW'(grab) * SumW'(held_value[q_head]);
				want = want - grab;
				if (grab == have) begin
					q_head = (q_head + 1 == QDEPTH) ? 0 : q_head + 1;
					q_runs--;
				end else begin
					held_count[q_head] = have - grab;
				end
			end
			if (want != 0)
				r.status = StShort;
		end
		return r;
	endfunction

	// Gap or stall length: mostly none or short, now and then long; none in a calm stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CountW-1:0] push_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 13)
			return $urandom();
		if (r < 16)
			return 32'hFFFF_FFFF;
		return $urandom_range(1, 8);
	endfunction

	function automatic logic [CountW-1:0] take_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 40)
			return $urandom_range(1, 16);
		if (r < 70)
			return $urandom_range(1, 64);
		if (r < 88)
			return $urandom_range(1, 2000);
		if (r < 97)
			return $urandom();
		return 32'hFFFF_FFFF;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is accepted.
	task automatic offer(input logic m, input logic [ValueW-1:0] v, input logic [CountW-1:0] c,
			input logic typed, input outcome_t given);
		int       gap;
		outcome_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		run_value <= v;
		unit_count <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_step(m, v, c);
		pending.insert(pending.size(), typed ? given : predicted);
		@(negedge clk);
	endtask

	task automatic offer_random(input logic m, input logic [CountW-1:0] c);
		outcome_t none;
		none = '0;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		offer(m, ValueW'($urandom_range(0, 16'hFFFF)), c, 1'b0, none);
	endtask

	initial begin : result_sink
		int left;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				left = HOLD_CYCLES;
			end else if (left == 0) begin
				left = pick_gap();
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, sum %0h status %0d", $time,
						weighted_sum, status);
			end else begin
				want = pending.pop_front();
				if (weighted_sum !== want.sum) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: weighted_sum expected %0h, got %0h", $time,
							want.sum, weighted_sum);
				end
				if (status !== want.status) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: status expected %0d, got %0d", $time,
							want.status, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int       n;
		int       drops;
		bit       held;
		logic     m;
		logic     [CountW-1:0] c;
		outcome_t given;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NROWS; i++) begin
			given.sum = STEPS[i].sum;
			given.status = STEPS[i].status;
			offer(STEPS[i].mode, STEPS[i].value, STEPS[i].count, STEPS[i].typed, given);
		end

		// Fill the queue until several pushes have been turned away, with the odd small take.
		drops = 0;
		held = 1'b0;
		n = 0;
		while (drops < 6 && n < 5000) begin
			if ($urandom_range(0, 49) == 0) begin
				offer_random(ModeTake, $urandom_range(1, 3));
			end else begin
				c = push_count();
				if (q_runs == QDEPTH && c != 0)
					drops++;
				offer_random(ModePush, c);
			end
			if (!held && q_runs == QDEPTH / 2) begin
				held = 1'b1;
				calm = 1'b1;
				hold_request = 1'b1;
			end
			n++;
		end

		// A long output hold-off while the input keeps pressing in.
		calm = 1'b1;
		hold_request = 1'b1;
		for (n = 0; n < 40; n++) begin
			m = ($urandom_range(0, 99) < 55) ? ModePush : ModeTake;
			offer_random(m, (m == ModePush) ? push_count() : take_count());
		end

		for (n = 0; n < 300 && q_runs != 0; n++)
			offer_random(ModeTake, 32'hFFFF_FFFF);

		// Work close to empty so that shortfalls and wrapped indexes are common.
		for (n = 0; n < 30; n++) begin
			if ($urandom_range(0, 1) == 0)
				offer_random(ModePush, push_count());
			else
				offer_random(ModeTake, $urandom_range(0, 12));
		end

		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
rtl/rlqwt_pkg.sv
rtl/rlqwt_ram.sv
rtl/run_length_queue_weighted_take_core.sv
dv/tb.sv
